@@ hw/rtl/png_scanline_unfilter_core_assert.svh @@
// Assertion macros for the PNG scanline unfilter block.
`ifndef PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define PNGSU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pngsu: same-cycle check failed");

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define PNGSU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pngsu: next-cycle check failed");

`endif

@@ hw/rtl/pngsu_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter block.
package pngsu_pkg;

    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int BPP_W     = 4;
    localparam int LEN_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_LINE_BYTES = 4096;
    localparam int DEF_MAX_BPP        = 8;

    localparam logic [BPP_W-1:0] RST_BPP      = BPP_W'(4);
    localparam logic [LEN_W-1:0] RST_LINE_LEN = LEN_W'(4096);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BPP      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Neighbor availability for the byte being reconstructed.
    typedef struct packed {
        logic first_row;
        logic has_left;
    } nbr_t;

endpackage

@@ hw/rtl/pngsu_line_store.sv @@
// Line store holding the previous scanline, with registered read and write bypass.
module pngsu_line_store
    import pngsu_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_LINE_BYTES,
    parameter int AW    = $clog2(DEF_MAX_LINE_BYTES)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // A read issued in the same cycle as a write to that column must see the new byte.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/pngsu_recon.sv @@
// Neighbor windows and the filter predictor that rebuild one raw byte.
module pngsu_recon
    import pngsu_pkg::*;
#(
    parameter int MAX_BPP = DEF_MAX_BPP,
    parameter int BIW     = $clog2(DEF_MAX_BPP)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [BIW-1:0]    bpp_idx,
    input  nbr_t              nbr,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [BYTE_W-1:0] data,
    input  logic [BYTE_W-1:0] above_raw,
    output logic [BYTE_W-1:0] pixel,
    output logic [BYTE_W-1:0] above
);

    logic [BYTE_W-1:0] left_win_reg    [MAX_BPP];
    logic [BYTE_W-1:0] upleft_win_reg  [MAX_BPP];

    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] upleft;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W:0]   avg_sum;
    logic signed [BYTE_W+1:0] diff_bc;
    logic signed [BYTE_W+1:0] diff_ac;
    logic signed [BYTE_W+1:0] diff_abc;
    logic [BYTE_W+1:0] pa;
    logic [BYTE_W+1:0] pb;
    logic [BYTE_W+1:0] pc;

    always_comb begin
        above  = nbr.first_row ? '0 : above_raw;
        left   = nbr.has_left ? left_win_reg[bpp_idx] : '0;
        upleft = (!nbr.first_row && nbr.has_left) ? upleft_win_reg[bpp_idx] : '0;
    end

    // With p = a + b - c the three distances reduce to |b - c|, |a - c| and |a + b - 2c|.
    always_comb begin
        diff_bc  = $signed({2'b00, above}) - $signed({2'b00, upleft});
        diff_ac  = $signed({2'b00, left}) - $signed({2'b00, upleft});
        diff_abc = diff_bc + diff_ac;
        pa = diff_bc[BYTE_W+1]  ? (BYTE_W+2)'(-diff_bc)  : diff_bc;
        pb = diff_ac[BYTE_W+1]  ? (BYTE_W+2)'(-diff_ac)  : diff_ac;
        pc = diff_abc[BYTE_W+1] ? (BYTE_W+2)'(-diff_abc) : diff_abc;
        if ((pa <= pb) && (pa <= pc)) begin
            paeth = left;
        end else if (pb <= pc) begin
            paeth = above;
        end else begin
            paeth = upleft;
        end
    end

    always_comb begin
        avg_sum = {1'b0, left} + {1'b0, above};
        case (filt_t'(cmd))
            FILT_SUB:   pred = left;
            FILT_UP:    pred = above;
            FILT_AVG:   pred = avg_sum[BYTE_W:1];
            FILT_PAETH: pred = paeth;
            default:    pred = '0;
        endcase
        pixel = data + pred;
    end

    // Both windows shift once for every byte that leaves the reconstruction stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_BPP; i++) begin
                left_win_reg[i]   <= '0;
                upleft_win_reg[i] <= '0;
            end
        end else if (advance) begin
            for (int i = MAX_BPP - 1; i > 0; i--) begin
                left_win_reg[i]   <= left_win_reg[i-1];
                upleft_win_reg[i] <= upleft_win_reg[i-1];
            end
            left_win_reg[0]   <= pixel;
            upleft_win_reg[0] <= above;
        end
    end

endmodule

@@ hw/rtl/png_scanline_unfilter_core.sv @@
// An input transfer passes the input stage, then the result register, before its result transfer.
// Throughput: one byte per cycle without stalls; the left-window update is the feedback loop.
// The line store is read when a byte is taken, and bypasses a write to the same column.
// Reset (aresetn low, synchronous) empties both stages, zeroes column and windows, sets first row
// and restores bytes_per_pixel to 4 and line_length to 4096; the line store is not cleared.
module png_scanline_unfilter_core
    import pngsu_pkg::*;
#(
    parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
    parameter int MAX_BPP        = DEF_MAX_BPP
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [BYTE_W-1:0]    s_data,
    input  logic                 s_new_image,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_pixel,
    output logic                 m_end_of_line
);

`include "png_scanline_unfilter_core_assert.svh"

    localparam int AW  = $clog2(MAX_LINE_BYTES);
    localparam int BIW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
    localparam int CW  = ((AW + 1) > LEN_W) ? (AW + 1) : LEN_W;

    logic [BPP_W-1:0]  bpp_reg;
    logic [LEN_W-1:0]  line_len_reg;
    logic [AW-1:0]     column_reg;
    logic              first_row_reg;

    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    nbr_t              s1_nbr_reg;
    logic              s1_last_reg;
    logic [AW-1:0]     s1_col_reg;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_pixel_reg;
    logic              m_eol_reg;

    logic              s_acc;
    logic              s1_adv;
    logic [BPP_W-1:0]  bpp_cl;
    logic [BIW-1:0]    bpp_idx;
    logic [CW-1:0]     len_ext;
    logic [CW-1:0]     len_cl;
    logic [AW-1:0]     col_in;
    logic [CW-1:0]     col_ext;
    logic              acc_last;
    nbr_t              acc_nbr;
    logic [BYTE_W-1:0] above_raw;
    logic [BYTE_W-1:0] recon_pixel;
    logic [BYTE_W-1:0] recon_above;

    // The input stage moves on whenever the result register is empty or being drained.
    assign s1_adv  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_acc   = s_valid && s_ready;

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_cl = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_BPP)) begin
            bpp_cl = BPP_W'(MAX_BPP);
        end else begin
            bpp_cl = bpp_reg;
        end
        bpp_idx = BIW'(bpp_cl - BPP_W'(1));

        len_ext = CW'(line_len_reg);
        if (len_ext == '0) begin
            len_cl = CW'(1);
        end else if (len_ext > CW'(MAX_LINE_BYTES)) begin
            len_cl = CW'(MAX_LINE_BYTES);
        end else begin
            len_cl = len_ext;
        end

        col_in            = s_new_image ? '0 : column_reg;
        col_ext           = CW'(col_in);
        acc_last          = (col_ext + CW'(1)) >= len_cl;
        acc_nbr.first_row = s_new_image || first_row_reg;
        acc_nbr.has_left  = col_ext >= CW'(bpp_cl);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg      <= RST_BPP;
            line_len_reg <= RST_LINE_LEN;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_BPP) begin
                bpp_reg <= cfg_wdata[BPP_W-1:0];
            end
            if (cfg_index == REG_LINE_LEN) begin
                line_len_reg <= cfg_wdata;
            end
        end
    end

    // Line position advances when a byte is taken, so the store read can start at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
        end else if (s_acc) begin
            if (acc_last) begin
                column_reg    <= '0;
                first_row_reg <= 1'b0;
            end else begin
                column_reg    <= col_in + AW'(1);
                first_row_reg <= acc_nbr.first_row;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_cmd_reg  <= s_cmd;
            s1_data_reg <= s_data;
            s1_nbr_reg  <= acc_nbr;
            s1_last_reg <= acc_last;
            s1_col_reg  <= col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_pixel_reg <= recon_pixel;
            m_eol_reg   <= s1_last_reg;
        end
    end

    pngsu_line_store #(
        .DEPTH (MAX_LINE_BYTES),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_in),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (recon_pixel),
        .rd_data (above_raw)
    );

    pngsu_recon #(
        .MAX_BPP (MAX_BPP),
        .BIW     (BIW)
    ) u_recon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s1_adv),
        .bpp_idx   (bpp_idx),
        .nbr       (s1_nbr_reg),
        .cmd       (s1_cmd_reg),
        .data      (s1_data_reg),
        .above_raw (above_raw),
        .pixel     (recon_pixel),
        .above     (recon_above)
    );

    assign m_valid       = m_valid_reg;
    assign m_pixel       = m_pixel_reg;
    assign m_end_of_line = m_eol_reg;

    `PNGSU_ASSERT_NXT(a_adv_fills_out, s1_adv, m_valid_reg)
    `PNGSU_ASSERT_IMP(a_column_in_range, 1'b1, CW'(column_reg) < CW'(MAX_LINE_BYTES))
    `PNGSU_ASSERT_NXT(a_last_wraps, s_acc && acc_last, (column_reg == '0) && !first_row_reg)
    `PNGSU_ASSERT_IMP(a_stall_cause, !s_ready, s1_valid_reg && m_valid_reg && !m_ready)
    `PNGSU_ASSERT_IMP(a_first_row_above_zero, s1_valid_reg && s1_nbr_reg.first_row,
                      recon_above == '0)

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the PNG scanline unfilter core: directed and random byte streams.
module testbench;
    import pngsu_pkg::*;

    localparam int LINE_MAX       = DEF_MAX_LINE_BYTES;
    localparam int BPP_MAX        = DEF_MAX_BPP;
    localparam int STALL_MAX      = 17;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES   = 600;
    localparam int PRINT_MAX      = 40;

    // Filter codes outside the defined set; the block treats them as no filter.
    localparam logic [CMD_W-1:0] FILT_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] FILT_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              end_of_line;
    } raw_byte_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    logic [BYTE_W-1:0]    s_data;
    logic                 s_new_image;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_pixel;
    logic                 m_end_of_line;

    png_scanline_unfilter_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data        (s_data),
        .s_new_image   (s_new_image),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel       (m_pixel),
        .m_end_of_line (m_end_of_line)
    );

    // Shadow of the block's state, updated once per input transfer.
    logic [BYTE_W-1:0] line_mem [LINE_MAX];
    bit                line_written [LINE_MAX];
    logic [BYTE_W-1:0] left_hist [BPP_MAX]  = '{default: '0};
    logic [BYTE_W-1:0] above_hist [BPP_MAX] = '{default: '0};
    int                col_pos  = 0;
    bit                top_row  = 1'b1;
    logic [BPP_W-1:0]  bpp_setting = RST_BPP;
    logic [LEN_W-1:0]  len_setting = RST_LINE_LEN;

    raw_byte_t pixels_due [$];
    int        err_count   = 0;
    bit        tx_idle_on  = 1'b1;
    bit        rx_idle_on  = 1'b1;
    int        rx_hold_len = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= PRINT_MAX)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic raw_byte_t unfilter_byte(input logic [CMD_W-1:0] cmd,
                                                input logic [BYTE_W-1:0] data,
                                                input logic new_img);
        int bpp, len, col, a, b, c, p, pa, pb, pc, pred, i;
        raw_byte_t r;
        bpp = (bpp_setting == 0) ? 1 : (bpp_setting > BPP_MAX) ? BPP_MAX : int'(bpp_setting);
        len = (len_setting == 0) ? 1 : (len_setting > LINE_MAX) ? LINE_MAX : int'(len_setting);
        if (new_img) begin
            col_pos = 0;
            top_row = 1'b1;
        end
        col = col_pos;
        a = (col >= bpp) ? int'(left_hist[bpp-1]) : 0;
        b = top_row ? 0 : int'(line_mem[col]);
        c = (!top_row && col >= bpp) ? int'(above_hist[bpp-1]) : 0;
        case (cmd)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) / 2;
            FILT_PAETH: begin
                p  = a + b - c;
                pa = (p > a) ? p - a : a - p;
                pb = (p > b) ? p - b : b - p;
                pc = (p > c) ? p - c : c - p;
                if (pa <= pb && pa <= pc)
                    pred = a;
                else if (pb <= pc)
                    pred = b;
                else
                    pred = c;
            end
            default:    pred = 0;
        endcase
        r.pixel = BYTE_W'(int'(data) + pred);
        for (i = BPP_MAX - 1; i > 0; i--) begin
            left_hist[i]  = left_hist[i-1];
            above_hist[i] = above_hist[i-1];
        end
        left_hist[0]      = r.pixel;
        above_hist[0]     = BYTE_W'(b);
        line_mem[col]     = r.pixel;
        line_written[col] = 1'b1;
        r.end_of_line = (col + 1 >= len);
        if (r.end_of_line) begin
            col_pos = 0;
            top_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
        return r;
    endfunction

    task automatic send_byte(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                             input logic new_img);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        // A column of the line store that was never written must not be read as the
        // byte above, so such a byte starts a fresh image instead.
        if (!new_img && !top_row && !line_written[col_pos])
            new_img = 1'b1;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data      <= data;
        s_new_image <= new_img;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pixels_due.push_back(unfilter_byte(cmd, data, new_img));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [BPP_W-1:0] bpp, input logic [LEN_W-1:0] len);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_BPP;
        cfg_wdata <= LEN_W'(bpp);
        @(posedge aclk);
        cfg_index <= REG_LINE_LEN;
        cfg_wdata <= len;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        bpp_setting = bpp;
        len_setting = len;
        @(posedge aclk);
    endtask

    // Reset settings: the opening bytes of a first row with the default pixel width.
    task automatic test_reset_defaults();
        int k;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (k = 0; k < 32; k++)
            send_byte(FILT_SUB, BYTE_W'($urandom_range(0, 255)), k == 0);
        for (k = 0; k < 16; k++)
            send_byte(FILT_PAETH, BYTE_W'($urandom_range(0, 255)), 1'b0);
        drain();
    endtask

    task automatic test_filter_kinds();
        logic [CMD_W-1:0] kinds [7] = '{FILT_NONE, FILT_SUB, FILT_UP, FILT_AVG, FILT_PAETH,
                                        FILT_RSVD_LO, FILT_RSVD_HI};
        int l, k;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        program_regs(BPP_W'(1), LEN_W'(3));
        for (l = 0; l < 7; l++) begin
            for (k = 0; k < 3; k++)
                send_byte(kinds[l], (k == 0) ? 8'hFF : (k == 1) ? 8'h00
                                   : BYTE_W'($urandom_range(0, 255)), l == 0 && k == 0);
        end
    endtask

    task automatic test_register_extremes();
        int k;
        // Zero bytes per pixel acts as one; zero line length makes every byte a line.
        program_regs(BPP_W'(0), LEN_W'(0));
        send_byte(FILT_SUB, 8'h81, 1'b1);
        send_byte(FILT_UP, 8'h7E, 1'b0);
        send_byte(FILT_AVG, 8'hFF, 1'b0);
        send_byte(FILT_PAETH, 8'h01, 1'b0);
        // Bytes per pixel above the maximum acts as the maximum.
        program_regs('1, LEN_W'(19));
        for (k = 0; k < 38; k++)
            send_byte((k < 19) ? FILT_SUB : FILT_PAETH, BYTE_W'($urandom_range(0, 255)), k == 0);
        program_regs(BPP_W'(BPP_MAX), LEN_W'(16));
        for (k = 0; k < 32; k++)
            send_byte((k < 16) ? FILT_AVG : FILT_PAETH, BYTE_W'($urandom_range(0, 255)), k == 0);
    endtask

    task automatic test_mid_line_changes();
        int k;
        program_regs(BPP_W'(3), LEN_W'(12));
        for (k = 0; k < 12; k++)
            send_byte(FILT_NONE, BYTE_W'($urandom_range(0, 255)), k == 0);
        // The filter type changes from byte to byte within one line.
        for (k = 0; k < 12; k++)
            send_byte(CMD_W'(k), BYTE_W'($urandom_range(0, 255)), 1'b0);
        for (k = 0; k < 8; k++)
            send_byte(FILT_AVG, BYTE_W'($urandom_range(0, 255)), 1'b0);
        // Shrinking the line below the current column ends the line at the next byte.
        program_regs(BPP_W'(3), LEN_W'(5));
        send_byte(FILT_PAETH, BYTE_W'($urandom_range(0, 255)), 1'b0);
        for (k = 0; k < 5; k++)
            send_byte(FILT_PAETH, BYTE_W'($urandom_range(0, 255)), 1'b0);
        for (k = 0; k < 4; k++)
            send_byte(FILT_UP, BYTE_W'($urandom_range(0, 255)), k == 2);
        // A line length above the store depth acts as the store depth.
        program_regs(BPP_W'(2), '1);
        for (k = 0; k < 10; k++)
            send_byte(FILT_SUB, BYTE_W'($urandom_range(0, 255)), k == 0);
        program_regs(BPP_W'(2), LEN_W'(6));
        send_byte(FILT_SUB, BYTE_W'($urandom_range(0, 255)), 1'b0);
        for (k = 0; k < 6; k++)
            send_byte(FILT_UP, BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_backpressure();
        int k;
        program_regs(BPP_W'(4), LEN_W'(10));
        tx_idle_on  = 1'b0;
        rx_hold_len = 300;
        for (k = 0; k < 60; k++)
            send_byte(FILT_PAETH, BYTE_W'($urandom_range(0, 255)), k == 0);
        // The sender stops until every byte so far has come out, then goes on.
        drain();
        tx_idle_on = 1'b1;
        for (k = 0; k < 20; k++)
            send_byte(FILT_AVG, BYTE_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_random_images();
        int sent, lines, len, row_len, l, k;
        bit fresh;
        logic [CMD_W-1:0] kind, cmd;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 24);
            program_regs(BPP_W'($urandom_range(0, 15)), LEN_W'(len));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            row_len = (len == 0) ? 1 : len;
            lines = (len > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6);
            fresh = ($urandom_range(0, 3) != 0);
            for (l = 0; l < lines; l++) begin
                if ($urandom_range(0, 9) == 0)
                    kind = CMD_W'($urandom_range(FILT_RSVD_LO, FILT_RSVD_HI));
                else
                    kind = CMD_W'($urandom_range(FILT_NONE, FILT_PAETH));
                for (k = 0; k < row_len; k++) begin
                    cmd = ($urandom_range(0, 39) == 0) ? CMD_W'($urandom_range(0, 7)) : kind;
                    send_byte(cmd, BYTE_W'($urandom_range(0, 255)),
                              (fresh && l == 0 && k == 0) || $urandom_range(0, 149) == 0);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= REG_BPP;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_cmd       <= FILT_NONE;
        s_data      <= '0;
        s_new_image <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_filter_kinds();
        test_register_extremes();
        test_mid_line_changes();
        test_backpressure();
        test_random_images();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pixels_due.size() != 0)
            report_mismatch($sformatf("%0d bytes never came out", pixels_due.size()));
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls per transfer, a long hold when asked, and the byte check.
    initial begin
        int rx_wait;
        raw_byte_t want;
        rx_wait = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                if (pixels_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_pixel));
                end else begin
                    want = pixels_due.pop_front();
                    if (m_pixel !== want.pixel)
                        report_mismatch($sformatf("pixel %02h, want %02h", m_pixel, want.pixel));
                    if (m_end_of_line !== want.end_of_line)
                        report_mismatch($sformatf("end_of_line %b, want %b",
                                                  m_end_of_line, want.end_of_line));
                end
                rx_wait = rx_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_hold_len > 0) begin
                rx_wait     = rx_hold_len;
                rx_hold_len = 0;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
